[sv/smg_pkg.sv]
// Shared definitions for the shuffled minimal-standard generator.
// Holds the generator constants, the controller state type and the command and status structs.
// No dependencies.
`default_nettype none

package smg_pkg;

    // Width of the Lehmer state and of every table entry.
    localparam int unsigned SEED_W = 31;

    // Lehmer constants: multiplier and the Mersenne prime modulus 2^31 - 1.
    localparam logic [14:0]       LEHMER_MULT = 15'd16807;
    localparam logic [SEED_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;

    // Largest numerator whose fraction stays at or below 1 - 1.2e-7.
    localparam logic [SEED_W-1:0] OUT_CLAMP = 31'd2147483389;

    // Extra warm-up steps taken before the table starts to fill.
    localparam int unsigned WARMUP_EXTRA = 8;

    // Default shuffle table depth.
    localparam int unsigned TABLE_DEPTH_DEF = 32;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WMUL,
        ST_WRED,
        ST_DMUL,
        ST_DRED,
        ST_RD,
        ST_WR
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // input beat taken: load the seed where required
        logic mul;       // register seed times multiplier
        logic red;       // fold the product back into the seed
        logic warm;      // the current step belongs to table construction
        logic div_init;  // register the slot quotient of the last output
        logic rd;        // read the selected table slot
        logic wr;        // refill the slot, update last output, present the result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_init;  // the beat on the input asks for a table build
        logic warm_last;  // the warm-up counter is on its final step
        logic out_free;   // the output register can take a result this cycle
    } status_t;

endpackage

`default_nettype wire

[sv/shuffled_minstd_generator_top.sv]
// Top level of the shuffled minimal-standard uniform generator.
// Instantiates smg_ctrl and smg_datapath; depends on smg_pkg.
`default_nettype none

// Each input beat yields exactly one output beat holding the numerator of a uniform
// fraction over 2^31 - 1, clamped to at most 2147483389. An item is taken only when the
// controller is idle and is handled one at a time: a plain draw runs the Lehmer step
// (multiply, with the slot quotient formed by a reciprocal multiply alongside it, then
// reduce), the registered table read and the refill. A reseed, or the first draw after
// reset, first rebuilds the table with further Lehmer steps: a warm-up, then one step
// per table slot. A finished result waits in the output register while the next beat
// is accepted; only the following refill stalls behind a full output register.
module shuffled_minstd_generator_top #(
    parameter int unsigned TABLE_DEPTH = smg_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] seed_value, [31] zero
    input  wire logic        s_tuser,   // [0] op: 0 draw, 1 reseed then draw
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [30:0] random_numerator, [31] zero
);

    smg_pkg::cmd_t    cmd;
    smg_pkg::status_t status;

    smg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    smg_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[sv/smg_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the shuffle table. No dependencies.
`default_nettype none

module smg_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/smg_datapath.sv]
// Datapath of the shuffled minimal-standard generator: Lehmer step, slot quotient,
// shuffle table and output register. Depends on smg_pkg and smg_ram.
`default_nettype none

module smg_datapath #(
    parameter int unsigned TABLE_DEPTH = smg_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire smg_pkg::cmd_t  cmd,
    output smg_pkg::status_t    status,
    input  wire logic [31:0]    s_tdata,
    input  wire logic           s_tuser,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [31:0]         m_tdata
);

    localparam int unsigned SW = smg_pkg::SEED_W;
    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned QW = AW + 1;
    localparam int unsigned JW = $clog2(TABLE_DEPTH + smg_pkg::WARMUP_EXTRA);
    localparam int unsigned RW = 32;
    localparam int unsigned PW = SW + RW;
    localparam longint unsigned SLOT_DIV = 64'(1 + (2147483646 / TABLE_DEPTH));
    localparam int unsigned RSH = SW + $clog2(SLOT_DIV);
    localparam longint unsigned RECIP = ((64'd1 << RSH) + SLOT_DIV - 64'd1) / SLOT_DIV;

    logic [SW-1:0] seed_reg,  seed_next;
    logic [45:0]   prod_reg,  prod_next;
    logic [SW-1:0] last_reg,  last_next;
    logic [QW-1:0] quo_reg,   quo_next;
    logic [JW-1:0] jcnt_reg,  jcnt_next;
    logic          oval_reg,  oval_next;
    logic [SW-1:0] odata_reg, odata_next;

    logic [SW-1:0] seed_in;
    logic [SW-1:0] seed_fixed;
    logic [31:0]   fold_sum;
    logic [SW-1:0] red_val;
    logic [PW-1:0] recip_prod;
    logic [AW-1:0] slot;
    logic          warm_wr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [SW-1:0] ram_wdata;
    logic [SW-1:0] ram_rdata;

    // Seed loading: zero and the modulus itself both load as one.
    assign seed_in    = s_tdata[SW-1:0];
    assign seed_fixed = (seed_in == '0 || seed_in == smg_pkg::LEHMER_MOD) ? SW'(1) : seed_in;

    // Mersenne fold: high bits of the product are added back onto the low bits.
    assign fold_sum = 32'(prod_reg[SW-1:0]) + 32'(prod_reg[45:SW]);
    assign red_val  = (fold_sum >= 32'(smg_pkg::LEHMER_MOD))
                    ? SW'(fold_sum - 32'(smg_pkg::LEHMER_MOD))
                    : fold_sum[SW-1:0];

    // Slot quotient by multiplying with the rounded-up reciprocal of the slot span;
    // the result is exact for every 31-bit last output.
    assign recip_prod = PW'(last_reg) * PW'(RW'(RECIP));

    // Slot limited to the table.
    assign slot = (quo_reg >= QW'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1) : quo_reg[AW-1:0];

    // Table write port: warm-up fill or refill after a draw.
    assign warm_wr   = cmd.red && cmd.warm && (jcnt_reg < JW'(TABLE_DEPTH));
    assign ram_we    = warm_wr || cmd.wr;
    assign ram_waddr = cmd.wr ? slot : jcnt_reg[AW-1:0];
    assign ram_wdata = cmd.wr ? seed_reg : red_val;

    smg_ram #(
        .WIDTH (SW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    // Next-state logic of the datapath registers.
    always_comb
    begin
        seed_next  = seed_reg;
        prod_next  = prod_reg;
        last_next  = last_reg;
        quo_next   = quo_reg;
        jcnt_next  = jcnt_reg;
        oval_next  = oval_reg && !m_tready;
        odata_next = odata_reg;

        if (cmd.accept)
        begin
            jcnt_next = JW'(TABLE_DEPTH + smg_pkg::WARMUP_EXTRA - 1);
            if (s_tuser)
            begin
                seed_next = seed_fixed;
            end
            else if (last_reg == '0)
            begin
                seed_next = SW'(1);
            end
        end
        if (cmd.mul)
        begin
            prod_next = 46'(seed_reg) * 46'(smg_pkg::LEHMER_MULT);
        end
        if (cmd.red)
        begin
            seed_next = red_val;
            if (cmd.warm)
            begin
                jcnt_next = jcnt_reg - JW'(1);
                if (jcnt_reg == '0)
                begin
                    last_next = red_val;
                end
            end
        end
        if (cmd.div_init)
        begin
            quo_next = QW'(recip_prod >> RSH);
        end
        if (cmd.wr)
        begin
            last_next  = ram_rdata;
            oval_next  = 1'b1;
            odata_next = (ram_rdata > smg_pkg::OUT_CLAMP) ? smg_pkg::OUT_CLAMP : ram_rdata;
        end
    end

    // Registers; the generator state and the output valid are reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SW'(1);
            last_reg <= '0;
            jcnt_reg <= '0;
            oval_reg <= 1'b0;
        end
        else
        begin
            seed_reg <= seed_next;
            last_reg <= last_next;
            jcnt_reg <= jcnt_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        quo_reg   <= quo_next;
        odata_reg <= odata_next;
    end

    // Status towards the controller.
    assign status.need_init = s_tuser || (last_reg == '0);
    assign status.warm_last = (jcnt_reg == '0);
    assign status.out_free  = !oval_reg || m_tready;

    assign m_tvalid = oval_reg;
    assign m_tdata  = {1'b0, odata_reg};

    // The Lehmer state never leaves the range one to modulus minus one.
    a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
        (seed_reg != '0) && (seed_reg != smg_pkg::LEHMER_MOD))
        else $error("Lehmer state out of range");

    // A presented result is always within the clamped range.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        oval_reg |-> (odata_reg != '0) && (odata_reg <= smg_pkg::OUT_CLAMP))
        else $error("Result outside the clamped range");

    // A result stalled by the sink is not overwritten by a refill.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (oval_reg && !m_tready) |-> !cmd.wr)
        else $error("Refill while the output register is still full");

endmodule

`default_nettype wire

[sv/smg_ctrl.sv]
// Controller state machine of the shuffled minimal-standard generator.
// Sequences table build, Lehmer steps, slot selection and table refill. Depends on smg_pkg.
`default_nettype none

module smg_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire smg_pkg::status_t  status,
    output smg_pkg::cmd_t          cmd
);

    smg_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smg_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = status.need_init ? smg_pkg::ST_WMUL : smg_pkg::ST_DMUL;
                end
            end
            smg_pkg::ST_WMUL: state_next = smg_pkg::ST_WRED;
            smg_pkg::ST_WRED:
            begin
                state_next = status.warm_last ? smg_pkg::ST_DMUL : smg_pkg::ST_WMUL;
            end
            smg_pkg::ST_DMUL: state_next = smg_pkg::ST_DRED;
            smg_pkg::ST_DRED: state_next = smg_pkg::ST_RD;
            smg_pkg::ST_RD:   state_next = smg_pkg::ST_WR;
            smg_pkg::ST_WR:
            begin
                if (status.out_free)
                begin
                    state_next = smg_pkg::ST_IDLE;
                end
            end
            default: state_next = smg_pkg::ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            smg_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            smg_pkg::ST_WMUL: cmd.mul = 1'b1;
            smg_pkg::ST_WRED:
            begin
                cmd.red  = 1'b1;
                cmd.warm = 1'b1;
            end
            smg_pkg::ST_DMUL:
            begin
                cmd.mul      = 1'b1;
                cmd.div_init = 1'b1;
            end
            smg_pkg::ST_DRED: cmd.red = 1'b1;
            smg_pkg::ST_RD:   cmd.rd  = 1'b1;
            smg_pkg::ST_WR:   cmd.wr  = status.out_free;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A finished draw waits in the refill state while the output register is full.
    a_wr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == smg_pkg::ST_WR && !status.out_free) |=> (state_reg == smg_pkg::ST_WR))
        else $error("Refill state left while the output was blocked");

endmodule

`default_nettype wire

[bench/smg_checker.sv]
// Scoreboard for the shuffled minimal-standard generator: watches both stream channels.
// Predicts every numerator from its own Lehmer and shuffle-table model and compares each beat.
// Depends on nothing but the signals handed in by the testbench top.
module smg_checker #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] seed_value, [31] zero
    input  logic        s_tuser,   // [0] op: 0 draw, 1 reseed then draw
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [30:0] random_numerator, [31] zero
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MULTIPLIER = 64'd16807;
    localparam logic [63:0] MODULUS    = 64'd2147483647;
    localparam logic [30:0] NUM_CLAMP  = 31'd2147483389;
    localparam int unsigned WARMUP     = 8;
    localparam logic [30:0] SLOT_SPAN  = 31'd1 + 31'd2147483646 / TABLE_DEPTH;
    localparam logic        OP_RESEED  = 1'b1;

    // Model state: Lehmer seed, previous unclamped draw and the shuffle table.
    logic [30:0] gen_seed;
    logic [30:0] prev_draw;
    logic [30:0] slots [TABLE_DEPTH];

    // Numerators still owed by the block, oldest first.
    logic [30:0] numerator_q [$];
    int          mismatch_count = 0;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // One step of the multiplicative congruential generator.
    function automatic logic [30:0] lehmer_step(input logic [30:0] s);
        logic [63:0] prod;
        prod = {33'd0, s} * MULTIPLIER;
        return 31'(prod % MODULUS);
    endfunction

    // Load a seed, warm up and fill the table; the final step lands in slot zero.
    function automatic void rebuild_table(input logic [30:0] seed_in);
        logic [30:0] s;
        int          j;
        s = 31'(({33'd0, seed_in}) % MODULUS);
        if (s == 31'd0)
            s = 31'd1;
        for (j = int'(TABLE_DEPTH + WARMUP) - 1; j >= 0; j--)
        begin
            s = lehmer_step(s);
            if (j < int'(TABLE_DEPTH))
                slots[j] = s;
        end
        gen_seed  = s;
        prev_draw = slots[0];
    endfunction

    // Work out the numerator that one accepted input beat produces.
    function automatic logic [30:0] next_numerator(input logic op, input logic [30:0] seed_in);
        logic [30:0] slot;
        logic [30:0] drawn;
        if (op == OP_RESEED)
            rebuild_table(seed_in);
        else if (prev_draw == 31'd0)
            rebuild_table(31'd1);
        gen_seed = lehmer_step(gen_seed);
        slot = prev_draw / SLOT_SPAN;
        if (slot >= TABLE_DEPTH)
            slot = 31'(TABLE_DEPTH - 1);
        drawn       = slots[slot];
        slots[slot] = gen_seed;
        prev_draw   = drawn;
        return (drawn > NUM_CLAMP) ? NUM_CLAMP : drawn;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Compare output beats first, then predict from input beats taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        logic [30:0] want;
        if (!rst_n)
        begin
            gen_seed  = 31'd1;
            prev_draw = 31'd0;
            foreach (slots[i])
                slots[i] = 31'd0;
            numerator_q.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (numerator_q.size() == 0)
                    report_mismatch($sformatf("unexpected output beat 0x%08h", m_tdata));
                else
                begin
                    want = numerator_q.pop_front();
                    if (m_tdata !== {1'b0, want})
                        report_mismatch($sformatf("numerator 0x%08h, expected 0x%08h",
                                                  m_tdata, {1'b0, want}));
                end
            end
            if (s_tvalid && s_tready)
                numerator_q.push_back(next_numerator(s_tuser, s_tdata[30:0]));
            pending <= numerator_q.size();
            errors  <= mismatch_count;
        end
    end

endmodule

[bench/tb_shuffled_minstd_generator_top.sv]
// Testbench top for the shuffled minimal-standard generator: clock, reset, stimulus and verdict.
// Drives draw and reseed beats with random gaps and back-pressure; checking lives in smg_checker.
// Depends on shuffled_minstd_generator_top, smg_pkg and smg_checker.
module tb_shuffled_minstd_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH        = 32;
    localparam int          RANDOM_BEATS = 950;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          HOLD_AFTER   = 250;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic        OP_DRAW      = 1'b0;
    localparam logic        OP_RESEED    = 1'b1;
    localparam logic [30:0] SEED_ALL1    = 31'h7FFF_FFFF;
    localparam logic [30:0] SEED_TOP     = 31'd2147483646;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [30:0] seed_value, [31] zero
    logic        s_tuser;   // [0] op: 0 draw, 1 reseed then draw
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [30:0] random_numerator, [31] zero
    logic        hold_off;
    int          errors;
    int          pending;
    int          sent_beats = 0;
    int          cycles = 0;

    always #1ns clk = ~clk;

    shuffled_minstd_generator_top #(.TABLE_DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    smg_checker #(.TABLE_DEPTH(DEPTH)) scoreboard (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    // Idle cycles before a beat; every fourth stretch of beats runs with no idling.
    function automatic int pick_gap(input int idx);
        if ((idx / 80) % 4 == 1)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Offer one beat after a random gap and wait for the handshake. Valid stays high
    // after acceptance so that a back-to-back beat needs only one assignment.
    task automatic send_beat(input logic op, input logic [30:0] seed);
        int gap;
        gap = pick_gap(sent_beats);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, seed};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_beats++;
    endtask

    // Seed for a random reseed: mostly random, sometimes an edge value.
    function automatic logic [30:0] pick_seed();
        case ($urandom_range(0, 11))
            0:       return 31'd0;
            1:       return 31'd1;
            2:       return SEED_TOP;
            3:       return SEED_ALL1;
            default: return 31'($urandom());
        endcase
    endfunction

    // Receiver: a random stall before each beat, plus the long hold-off when asked.
    initial
    begin
        int stall_left;
        int taken;
        stall_left = 0;
        taken      = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (m_tvalid && m_tready)
                begin
                    taken++;
                    stall_left = ((taken / 70) % 4 == 2) ? 0 : $urandom_range(0, 13);
                end
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= !hold_off;
            end
        end
    end

    // Long receiver hold-off so the block fills up and pushes back on the input.
    initial
    begin
        int seen;
        seen = 0;
        hold_off <= 1'b0;
        while (seen < HOLD_AFTER)
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                seen++;
        end
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Reset, directed beats, random beats, drain and verdict.
    initial
    begin
        logic        op;
        logic [30:0] seed;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_DRAW;
        s_tdata  <= 32'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First draw after reset builds the table from seed one; the seed field is ignored.
        send_beat(OP_DRAW, SEED_ALL1);
        send_beat(OP_DRAW, 31'd0);
        send_beat(OP_DRAW, 31'h2AAA_AAAA);
        // Zero seed is loaded as one.
        send_beat(OP_RESEED, 31'd0);
        send_beat(OP_DRAW, 31'h5555_5555);
        send_beat(OP_RESEED, 31'd1);
        send_beat(OP_DRAW, 31'd0);
        // Seed equal to the modulus folds to zero and hence to one.
        send_beat(OP_RESEED, SEED_ALL1);
        send_beat(OP_DRAW, 31'd0);
        send_beat(OP_RESEED, SEED_TOP);
        send_beat(OP_DRAW, 31'd0);
        send_beat(OP_DRAW, SEED_ALL1);
        send_beat(OP_RESEED, 31'h5555_5555);
        send_beat(OP_RESEED, 31'h2AAA_AAAA);
        send_beat(OP_DRAW, 31'd0);
        send_beat(OP_RESEED, 31'h4000_0000);
        send_beat(OP_DRAW, 31'd0);
        send_beat(OP_DRAW, 31'd0);
        send_beat(OP_DRAW, 31'd0);
        send_beat(OP_DRAW, 31'd0);

        // Random part: mostly long runs of draws, with occasional reseeds.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            op   = ($urandom_range(0, 99) < 10) ? OP_RESEED : OP_DRAW;
            seed = (op == OP_RESEED) ? pick_seed() : 31'($urandom());
            send_beat(op, seed);
        end
        s_tvalid <= 1'b0;

        // Let the scoreboard see the last beat, then drain and linger.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
